// ===== design/dws_pkg.sv =====
// Package for the daily window switch: register map, config type and time helper.
`default_nettype none
package dws_pkg;

	localparam int unsigned HourW  = 5;
	localparam int unsigned MinW   = 6;
	localparam int unsigned LevelW = 8;
	localparam int unsigned TodW   = 11;	// 31*60+63 fits in 11 bits
	localparam int unsigned AddrW  = 5;
	localparam int unsigned DataW  = 32;

	// Register indexes, byte address is 4*index
	typedef enum logic [2:0] {
		REG_ON_HOUR       = 3'd0,
		REG_ON_MINUTE     = 3'd1,
		REG_OFF_HOUR      = 3'd2,
		REG_OFF_MINUTE    = 3'd3,
		REG_ENABLE_BITS   = 3'd4,
		REG_NORMAL_LEVEL  = 3'd5,
		REG_HOLD_SECONDS  = 3'd6,
		REG_TRIGGER_LEVEL = 3'd7
	} reg_idx_t;

	// Window settings handed to the compare logic
	typedef struct packed {
		logic [HourW-1:0] on_hour;
		logic [MinW-1:0]  on_minute;
		logic [HourW-1:0] close_hour;
		logic [MinW-1:0]  off_minute;
	} window_cfg_t;

	// Minute of day: hour*60 + minute, as (hour<<6) - (hour<<2) + minute
	function automatic logic [TodW-1:0] tod(input logic [HourW-1:0] h,
		input logic [MinW-1:0] m);
		logic [TodW-1:0] hx;
		hx = {{(TodW-HourW){1'b0}}, h};
		return (hx << 6) - (hx << 2) + {{(TodW-MinW){1'b0}}, m};
	endfunction

endpackage
`default_nettype wire

// ===== design/daily_window_switch_with_sensor_hold.sv =====
// Top level: daily on/off switch with motion-sensor hold, APB registers, result register.
// One evaluation per transaction: each accepted input gives one drive_level result in the
// next cycle, and a new input is taken every cycle while the result register is empty
// or being drained in the same cycle, so the sustained rate is one item per clock. The
// hold countdown and the window compare sit between the input port and the result
// register. Registers live at byte addresses 0x00..0x1C (index*4); writes take effect
// at the access phase and should only be made while no result is outstanding.
`default_nettype none
module daily_window_switch_with_sensor_hold import dws_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// APB configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [AddrW-1:0]  paddr,
	input  logic [DataW-1:0]  pwdata,
	output logic [DataW-1:0]  prdata,
	output logic              pready,
	// input channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [HourW-1:0]  now_hour,
	input  logic [MinW-1:0]   now_minute,
	input  logic              motion,
	input  logic              second_strobe,
	// result channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic [LevelW-1:0] drive_level
);

	window_cfg_t       win_cfg_q;
	logic [1:0]        enable_bits_q;
	logic [LevelW-1:0] normal_level_q;
	logic [LevelW-1:0] hold_seconds_q;
	logic [LevelW-1:0] trigger_level_q;
	logic [LevelW-1:0] hold_q;
	logic              out_valid_q;
	logic [LevelW-1:0] drive_level_q;

	reg_idx_t          reg_idx;
	logic              cfg_wr;
	logic              in_acc;
	logic              in_window;
	logic              timer_on;
	logic              trig_on;
	logic [LevelW-1:0] level_d;
	logic [LevelW-1:0] hold_d;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[AddrW-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_cfg_q       <= '0;
			enable_bits_q   <= '0;
			normal_level_q  <= '0;
			hold_seconds_q  <= '0;
			trigger_level_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_ON_HOUR:       win_cfg_q.on_hour    <= pwdata[HourW-1:0];
				REG_ON_MINUTE:     win_cfg_q.on_minute  <= pwdata[MinW-1:0];
				REG_OFF_HOUR:      win_cfg_q.close_hour <= pwdata[HourW-1:0];
				REG_OFF_MINUTE:    win_cfg_q.off_minute <= pwdata[MinW-1:0];
				REG_ENABLE_BITS:   enable_bits_q        <= pwdata[1:0];
				REG_NORMAL_LEVEL:  normal_level_q       <= pwdata[LevelW-1:0];
				REG_HOLD_SECONDS:  hold_seconds_q       <= pwdata[LevelW-1:0];
				REG_TRIGGER_LEVEL: trigger_level_q      <= pwdata[LevelW-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			REG_ON_HOUR:       prdata = DataW'(win_cfg_q.on_hour);
			REG_ON_MINUTE:     prdata = DataW'(win_cfg_q.on_minute);
			REG_OFF_HOUR:      prdata = DataW'(win_cfg_q.close_hour);
			REG_OFF_MINUTE:    prdata = DataW'(win_cfg_q.off_minute);
			REG_ENABLE_BITS:   prdata = DataW'(enable_bits_q);
			REG_NORMAL_LEVEL:  prdata = DataW'(normal_level_q);
			REG_HOLD_SECONDS:  prdata = DataW'(hold_seconds_q);
			REG_TRIGGER_LEVEL: prdata = DataW'(trigger_level_q);
			default:           prdata = '0;
		endcase
	end

	dws_window u_window (
		.cfg        (win_cfg_q),
		.now_hour   (now_hour),
		.now_minute (now_minute),
		.in_window  (in_window)
	);

	// decision order: disabled, motion, hold running, daily window
	assign timer_on = enable_bits_q[0];
	assign trig_on  = enable_bits_q[1];

	always_comb begin
		hold_d = hold_q;
		if (!timer_on) begin
			level_d = '0;
		end else if (motion && trig_on) begin
			level_d = trigger_level_q;
			hold_d  = hold_seconds_q;
		end else if ((hold_q != '0) && trig_on) begin
			level_d = trigger_level_q;
			if (second_strobe) begin
				hold_d = hold_q - LevelW'(1);
			end
		end else begin
			level_d = in_window ? normal_level_q : '0;
		end
	end

	// handshake: take a transaction whenever the result slot is free or draining
	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				hold_q <= hold_d;
			end
			if (in_acc) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			drive_level_q <= level_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign drive_level = drive_level_q;

	// an accepted transaction always leaves a result behind
	a_acc_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_valid)
		else $error("accepted transaction left no result");

	// timer disabled gives a zero drive
	a_disabled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !timer_on) |=> (drive_level == '0))
		else $error("drive non-zero with timer disabled");

	// hold count only moves on an accepted transaction
	a_hold_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_acc && !cfg_wr) |=> $stable(hold_q))
		else $error("hold count moved without a transaction");

	// without motion the hold count never rises
	a_hold_counts_down: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !motion) |=> (hold_q == $past(hold_q) ||
			hold_q == $past(hold_q) - LevelW'(1)))
		else $error("hold count jumped without motion");

endmodule
`default_nettype wire

// ===== design/dws_window.sv =====
// Daily on/off window test on minute of day, with wrap past midnight.
`default_nettype none
module dws_window import dws_pkg::*; (
	input  window_cfg_t       cfg,
	input  logic [HourW-1:0]  now_hour,
	input  logic [MinW-1:0]   now_minute,
	output logic              in_window
);

	logic [TodW-1:0] cur_tod;
	logic [TodW-1:0] on_tod;
	logic [TodW-1:0] off_tod;

	assign cur_tod = tod(now_hour, now_minute);
	assign on_tod  = tod(cfg.on_hour, cfg.on_minute);
	assign off_tod = tod(cfg.close_hour, cfg.off_minute);

	// Plain window, wrapped window, or the single on minute when equal
	always_comb begin
		if (off_tod > on_tod) begin
			in_window = (cur_tod >= on_tod) && (cur_tod < off_tod);
		end else if (off_tod < on_tod) begin
			in_window = (cur_tod >= on_tod) || (cur_tod < off_tod);
		end else begin
			in_window = (cur_tod == on_tod);
		end
	end

endmodule
`default_nettype wire
